### hdl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg: shared types, constants and arithmetic helpers
// Fixed-point helpers for the staggered-grid momentum flux pipeline.
// ----------------------------------------------------------------------------
package smf_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int NUM_STAGES = 9;
   localparam int CFG_BITS   = 31;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_DX       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DY       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_REYNOLDS = 2'd2;

   localparam logic [CFG_BITS-1:0] INV_DX_RESET       = 31'd65536;
   localparam logic [CFG_BITS-1:0] INV_DY_RESET       = 31'd65536;
   localparam logic [CFG_BITS-1:0] INV_REYNOLDS_RESET = 31'd655;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   localparam logic signed [63:0] WIDE_MAX  = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] WIDE_MIN  = 64'shFFFF_FFFF_8000_0000;
   localparam logic signed [63:0] ROUND_ADD = 64'sd1 <<< (FRAC_BITS - 1);

   localparam logic signed [33:0] SUM_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] SUM_MIN = 34'sh3_8000_0000;

   typedef logic signed [31:0] q_type;
   typedef logic signed [63:0] prod_type;

   typedef struct packed {
      logic  clip;
      q_type val;
   } satq_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] inv_dx;
      logic [CFG_BITS-1:0] inv_dy;
      logic [CFG_BITS-1:0] inv_reynolds;
   } cfg_type;

   typedef struct packed {
      logic  operation;
      q_type center_value;
      q_type east_value;
      q_type west_value;
      q_type north_value;
      q_type south_value;
      q_type cross_plus_a;
      q_type cross_plus_b;
      q_type cross_minus_a;
      q_type cross_minus_b;
   } req_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctl_type;

   typedef struct packed {
      logic     operation;
      logic     clip;
      q_type    diff_a;
      q_type    diff_b;
      prod_type lap_x_prod;
      prod_type lap_y_prod;
   } front_type;

   // clip a 34-bit exact sum to the signed 32-bit range
   function automatic satq_type sat_sum(input logic signed [33:0] x);
      satq_type r;
      if (x > SUM_MAX) begin
         r.clip = 1'b1;
         r.val  = Q_MAX;
      end else if (x < SUM_MIN) begin
         r.clip = 1'b1;
         r.val  = Q_MIN;
      end else begin
         r.clip = 1'b0;
         r.val  = x[31:0];
      end
      return r;
   endfunction

   function automatic satq_type add_sat(input q_type a, input q_type b);
      logic signed [33:0] s;
      s = {{2{a[31]}}, a} + {{2{b[31]}}, b};
      return sat_sum(s);
   endfunction

   function automatic satq_type sub_sat(input q_type a, input q_type b);
      logic signed [33:0] s;
      s = {{2{a[31]}}, a} - {{2{b[31]}}, b};
      return sat_sum(s);
   endfunction

   // floor of the half sum; always fits 32 bits
   function automatic q_type avg2(input q_type a, input q_type b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      return s[32:1];
   endfunction

   // round half up, drop the fraction bits, clip
   function automatic satq_type qround(input prod_type p);
      prod_type r;
      prod_type s;
      satq_type o;
      r = p + ROUND_ADD;
      s = r >>> FRAC_BITS;
      if (s > WIDE_MAX) begin
         o.clip = 1'b1;
         o.val  = Q_MAX;
      end else if (s < WIDE_MIN) begin
         o.clip = 1'b1;
         o.val  = Q_MIN;
      end else begin
         o.clip = 1'b0;
         o.val  = s[31:0];
      end
      return o;
   endfunction

   function automatic q_type cfg_to_q(input logic [CFG_BITS-1:0] v);
      return $signed({1'b0, v});
   endfunction

endpackage

### hdl/staggered_momentum_flux_stencil.sv
// ----------------------------------------------------------------------------
// staggered_momentum_flux_stencil: staggered-grid momentum flux pipeline
// Computes the x-momentum term F or the y-momentum term G of one cell per
// transaction in signed Q16.16, with saturation and a clip flag.
// ----------------------------------------------------------------------------
// Pipeline: nine register stages; the first loads at the request transaction
// edge, and rsp_tvalid rises when the transaction reaches the ninth stage.
// Throughput: one transaction per cycle unless rsp_tready stalls the output;
// each stage loads whenever it is empty or its successor drains.
// Reset: synchronous, active high; clears all stage valid bits and loads
// inv_dx = inv_dy = 1.0 and inv_reynolds = 655 (about 0.01).
module staggered_momentum_flux_stencil (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // center_value, east_value, west_value, north_value, south_value,
   // cross_plus_a, cross_plus_b, cross_minus_a, cross_minus_b (32 bits each)
   input  logic [287:0]                    req_tdata,
   // operation (0 = F, 1 = G)
   input  logic                            req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // flux (32 bits)
   output logic [31:0]                     rsp_tdata,
   // saturated
   output logic                            rsp_tuser,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [smf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [smf_pkg::CFG_BITS-1:0]    csr_data
);
   import smf_pkg::*;

   // Register file: always ready, ignore indexes past the list.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INV_DX:       cfg_in.inv_dx       = csr_data;
            CSR_INV_DY:       cfg_in.inv_dy       = csr_data;
            CSR_INV_REYNOLDS: cfg_in.inv_reynolds = csr_data;
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_dx       <= INV_DX_RESET;
         cfg_ff.inv_dy       <= INV_DY_RESET;
         cfg_ff.inv_reynolds <= INV_REYNOLDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // Unpack the request transaction; center value sits in the lowest bits.
   req_type req;

   always_comb begin
      req.operation     = req_tuser;
      req.center_value  = req_tdata[31:0];
      req.east_value    = req_tdata[63:32];
      req.west_value    = req_tdata[95:64];
      req.north_value   = req_tdata[127:96];
      req.south_value   = req_tdata[159:128];
      req.cross_plus_a  = req_tdata[191:160];
      req.cross_plus_b  = req_tdata[223:192];
      req.cross_minus_a = req_tdata[255:224];
      req.cross_minus_b = req_tdata[287:256];
   end

   // Stage control: per-stage valid bits, load enables ripple back from the
   // output so a stalled result holds while empty stages keep filling.
   stage_ctl_type ctl;

   smf_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   // Stages 1-4: averages, convective products, differences.
   front_type front;

   smf_front u_front (
      .clock (clock),
      .ctl   (ctl),
      .cfg   (cfg_ff),
      .req   (req),
      .front (front)
   );

   // Stages 5-9: spacing and viscous scaling, final difference and negation.
   q_type flux;
   logic  saturated;

   smf_back u_back (
      .clock     (clock),
      .ctl       (ctl),
      .cfg       (cfg_ff),
      .front     (front),
      .flux      (flux),
      .saturated (saturated)
   );

   assign rsp_tdata = flux;
   assign rsp_tuser = saturated;

endmodule

### hdl/smf_ctl.sv
// ----------------------------------------------------------------------------
// smf_ctl: pipeline valid and stall control
// Tracks a valid bit per stage and lets each stage load when it is empty or
// its successor moves, so bubbles collapse under backpressure.
// ----------------------------------------------------------------------------
module smf_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output smf_pkg::stage_ctl_type ctl
);
   import smf_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] move;

   always_comb begin
      move[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
   end

   always_comb begin
      valid_in[0] = move[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = move[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load   = move;
   assign req_tready = move[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

endmodule

### hdl/smf_front.sv
// ----------------------------------------------------------------------------
// smf_front: stages one to four
// Face averages and Laplacian sums, the convective products and spacing
// squares, their rounding, then the convective differences and the
// Laplacian scaling products.
// ----------------------------------------------------------------------------
module smf_front (
   input  logic                  clock,
   input  smf_pkg::stage_ctl_type ctl,
   input  smf_pkg::cfg_type       cfg,
   input  smf_pkg::req_type       req,
   output smf_pkg::front_type     front
);
   import smf_pkg::*;

   // stage 1: averages and Laplacian sums
   logic     op1_ff, op1_in;
   logic     clip1_ff, clip1_in;
   q_type    mul_a1_ff [4];
   q_type    mul_a1_in [4];
   q_type    mul_b1_ff [4];
   q_type    mul_b1_in [4];
   q_type    lapx1_ff, lapx1_in;
   q_type    lapy1_ff, lapy1_in;

   q_type    avg_ce, avg_cw, avg_cn, avg_cs, avg_p, avg_m;
   q_type    c_v, e_v, w_v, n_v, s_v;
   logic signed [33:0] lapx_sum, lapy_sum;
   satq_type lapx_sat, lapy_sat;

   always_comb begin
      c_v = req.center_value;
      e_v = req.east_value;
      w_v = req.west_value;
      n_v = req.north_value;
      s_v = req.south_value;

      avg_ce = avg2(c_v, e_v);
      avg_cw = avg2(c_v, w_v);
      avg_cn = avg2(c_v, n_v);
      avg_cs = avg2(c_v, s_v);
      avg_p  = avg2(req.cross_plus_a, req.cross_plus_b);
      avg_m  = avg2(req.cross_minus_a, req.cross_minus_b);

      if (!req.operation) begin
         mul_a1_in[0] = avg_ce; mul_b1_in[0] = avg_ce;
         mul_a1_in[1] = avg_cw; mul_b1_in[1] = avg_cw;
         mul_a1_in[2] = avg_cn; mul_b1_in[2] = avg_p;
         mul_a1_in[3] = avg_cs; mul_b1_in[3] = avg_m;
      end else begin
         mul_a1_in[0] = avg_cn; mul_b1_in[0] = avg_cn;
         mul_a1_in[1] = avg_cs; mul_b1_in[1] = avg_cs;
         mul_a1_in[2] = avg_p;  mul_b1_in[2] = avg_ce;
         mul_a1_in[3] = avg_m;  mul_b1_in[3] = avg_cw;
      end

      lapx_sum = {{2{e_v[31]}}, e_v} - {c_v[31], c_v, 1'b0} + {{2{w_v[31]}}, w_v};
      lapy_sum = {{2{n_v[31]}}, n_v} - {c_v[31], c_v, 1'b0} + {{2{s_v[31]}}, s_v};
      lapx_sat = sat_sum(lapx_sum);
      lapy_sat = sat_sum(lapy_sum);

      lapx1_in = lapx_sat.val;
      lapy1_in = lapy_sat.val;
      clip1_in = lapx_sat.clip | lapy_sat.clip;
      op1_in   = req.operation;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         op1_ff    <= op1_in;
         clip1_ff  <= clip1_in;
         mul_a1_ff <= mul_a1_in;
         mul_b1_ff <= mul_b1_in;
         lapx1_ff  <= lapx1_in;
         lapy1_ff  <= lapy1_in;
      end
   end

   // stage 2: raw products
   logic     op2_ff, clip2_ff;
   prod_type prod2_ff [4];
   prod_type prod2_in [4];
   prod_type dx2p2_ff, dx2p2_in;
   prod_type dy2p2_ff, dy2p2_in;
   q_type    lapx2_ff, lapy2_ff;
   q_type    idx_q, idy_q;

   always_comb begin
      idx_q = cfg_to_q(cfg.inv_dx);
      idy_q = cfg_to_q(cfg.inv_dy);
      for (int i = 0; i < 4; i++) begin
         prod2_in[i] = mul_a1_ff[i] * mul_b1_ff[i];
      end
      dx2p2_in = idx_q * idx_q;
      dy2p2_in = idy_q * idy_q;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         op2_ff   <= op1_ff;
         clip2_ff <= clip1_ff;
         prod2_ff <= prod2_in;
         dx2p2_ff <= dx2p2_in;
         dy2p2_ff <= dy2p2_in;
         lapx2_ff <= lapx1_ff;
         lapy2_ff <= lapy1_ff;
      end
   end

   // stage 3: round products
   logic     op3_ff, clip3_ff, clip3_in;
   q_type    q3_ff [4];
   q_type    q3_in [4];
   q_type    dx2_3_ff, dx2_3_in;
   q_type    dy2_3_ff, dy2_3_in;
   q_type    lapx3_ff, lapy3_ff;
   satq_type rnd3 [4];
   satq_type rnd_dx2, rnd_dy2;

   always_comb begin
      clip3_in = clip2_ff;
      for (int i = 0; i < 4; i++) begin
         rnd3[i]  = qround(prod2_ff[i]);
         q3_in[i] = rnd3[i].val;
         clip3_in = clip3_in | rnd3[i].clip;
      end
      rnd_dx2  = qround(dx2p2_ff);
      rnd_dy2  = qround(dy2p2_ff);
      dx2_3_in = rnd_dx2.val;
      dy2_3_in = rnd_dy2.val;
      clip3_in = clip3_in | rnd_dx2.clip | rnd_dy2.clip;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         op3_ff   <= op2_ff;
         clip3_ff <= clip3_in;
         q3_ff    <= q3_in;
         dx2_3_ff <= dx2_3_in;
         dy2_3_ff <= dy2_3_in;
         lapx3_ff <= lapx2_ff;
         lapy3_ff <= lapy2_ff;
      end
   end

   // stage 4: convective differences, Laplacian scaling products
   front_type front_ff, front_in;
   satq_type  diff_a4, diff_b4;

   always_comb begin
      diff_a4              = sub_sat(q3_ff[0], q3_ff[1]);
      diff_b4              = sub_sat(q3_ff[2], q3_ff[3]);
      front_in.operation   = op3_ff;
      front_in.clip        = clip3_ff | diff_a4.clip | diff_b4.clip;
      front_in.diff_a      = diff_a4.val;
      front_in.diff_b      = diff_b4.val;
      front_in.lap_x_prod  = lapx3_ff * dx2_3_ff;
      front_in.lap_y_prod  = lapy3_ff * dy2_3_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

### hdl/smf_back.sv
// ----------------------------------------------------------------------------
// smf_back: stages five to nine
// Spacing scaling of the convective terms, viscous sum and Reynolds
// scaling, then the final difference and negation into the output register.
// ----------------------------------------------------------------------------
module smf_back (
   input  logic                  clock,
   input  smf_pkg::stage_ctl_type ctl,
   input  smf_pkg::cfg_type       cfg,
   input  smf_pkg::front_type     front,
   output smf_pkg::q_type         flux,
   output logic                  saturated
);
   import smf_pkg::*;

   // stage 5: scale convective differences, round Laplacian terms
   logic     clip5_ff, clip5_in;
   prod_type pa5_ff, pa5_in;
   prod_type pb5_ff, pb5_in;
   q_type    lx5_ff, ly5_ff;
   q_type    scale_a, scale_b;
   satq_type rnd_lx, rnd_ly;

   always_comb begin
      scale_a  = front.operation ? cfg_to_q(cfg.inv_dy) : cfg_to_q(cfg.inv_dx);
      scale_b  = front.operation ? cfg_to_q(cfg.inv_dx) : cfg_to_q(cfg.inv_dy);
      pa5_in   = front.diff_a * scale_a;
      pb5_in   = front.diff_b * scale_b;
      rnd_lx   = qround(front.lap_x_prod);
      rnd_ly   = qround(front.lap_y_prod);
      clip5_in = front.clip | rnd_lx.clip | rnd_ly.clip;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         clip5_ff <= clip5_in;
         pa5_ff   <= pa5_in;
         pb5_ff   <= pb5_in;
         lx5_ff   <= rnd_lx.val;
         ly5_ff   <= rnd_ly.val;
      end
   end

   // stage 6: round convective terms, sum Laplacian terms
   logic     clip6_ff, clip6_in;
   q_type    a6_ff, b6_ff, lsum6_ff;
   satq_type rnd_a, rnd_b, lsum;

   always_comb begin
      rnd_a    = qround(pa5_ff);
      rnd_b    = qround(pb5_ff);
      lsum     = add_sat(lx5_ff, ly5_ff);
      clip6_in = clip5_ff | rnd_a.clip | rnd_b.clip | lsum.clip;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         clip6_ff <= clip6_in;
         a6_ff    <= rnd_a.val;
         b6_ff    <= rnd_b.val;
         lsum6_ff <= lsum.val;
      end
   end

   // stage 7: convective sum, viscous product
   logic     clip7_ff;
   q_type    ab7_ff;
   prod_type pv7_ff, pv7_in;
   satq_type ab_sum;

   always_comb begin
      ab_sum = add_sat(a6_ff, b6_ff);
      pv7_in = cfg_to_q(cfg.inv_reynolds) * lsum6_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         clip7_ff <= clip6_ff | ab_sum.clip;
         ab7_ff   <= ab_sum.val;
         pv7_ff   <= pv7_in;
      end
   end

   // stage 8: round viscous term
   logic     clip8_ff;
   q_type    ab8_ff, v8_ff;
   satq_type rnd_v;

   always_comb begin
      rnd_v = qround(pv7_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[7]) begin
         clip8_ff <= clip7_ff | rnd_v.clip;
         ab8_ff   <= ab7_ff;
         v8_ff    <= rnd_v.val;
      end
   end

   // stage 9: subtract viscous term and negate
   logic     sat9_ff, sat9_in;
   q_type    flux9_ff, flux9_in;
   satq_type total;

   always_comb begin
      total = sub_sat(ab8_ff, v8_ff);
      if (total.val == Q_MIN) begin
         flux9_in = Q_MAX;
         sat9_in  = 1'b1;
      end else begin
         flux9_in = -total.val;
         sat9_in  = clip8_ff | total.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[8]) begin
         sat9_ff  <= sat9_in;
         flux9_ff <= flux9_in;
      end
   end

   assign flux      = flux9_ff;
   assign saturated = sat9_ff;

endmodule
